// ===== rtl/eac_pkg.sv =====
package eac_pkg;

	typedef enum logic [1:0] {
		ALARM_NONE      = 2'd0,
		ALARM_GAS       = 2'd1,
		ALARM_FIRE      = 2'd2,
		ALARM_INTRUSION = 2'd3
	} alarm_t;

	typedef enum logic [1:0] {
		RELAY_OFF  = 2'd0,
		RELAY_ON   = 2'd1,
		RELAY_KEEP = 2'd2
	} relay_t;

	typedef struct packed {
		logic signed [11:0] temp_a;
		logic signed [11:0] temp_b;
		logic [9:0]         humid_a;
		logic [9:0]         humid_b;
		logic [15:0]        light_a;
		logic [15:0]        light_b;
		logic               motion_a;
		logic               motion_b;
		logic               shake_a;
		logic               shake_b;
		logic [11:0]        gas_adc;
	} sensor_t;

	typedef struct packed {
		logic [6:0] comfort;
		logic [6:0] fan_level;
		logic [2:0] lamp_count;
		logic [1:0] gas_band;
		logic [6:0] hazard_pts;
		logic       fire_risk;
		logic       intrusion_flag;
		logic [1:0] alarm_kind;
		logic       fan_on;
		logic [6:0] fan_speed_cmd;
		logic [1:0] light_relay;
		logic       siren_on;
	} result_t;

	// comfort / 400: c >> 4 then multiply by ceil(2^16 / 25)
	localparam logic [11:0] COMFORT_RECIP = 12'd2622;
	localparam int unsigned COMFORT_SHIFT = 16;
	localparam logic [15:0] COMFORT_MAX   = 16'd40000;
	localparam logic [15:0] MOTION_BONUS  = 16'd2000;

	localparam int unsigned TREND_MARGIN  = 100;

endpackage

// ===== rtl/eac_sensor_if.sv =====
interface eac_sensor_if;
	logic             valid;
	logic             ready;
	eac_pkg::sensor_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/eac_result_if.sv =====
interface eac_result_if;
	logic             valid;
	logic             ready;
	eac_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/environment_alarm_controller_unit.sv =====
// Environment alarm controller.
// sensor: one request per sensor round (two nodes of temperature, humidity,
//   light, motion and vibration, plus one gas reading).
// result: one request per round with comfort, fan, lamp, gas band, danger,
//   fire and intrusion flags, the chosen alarm and the actuator commands.
// Pipeline: an accepted round passes the input register, then the result
//   register, before it is offered on result.
// Throughput: one round per cycle unless result holds off; the gas trend sums
//   are kept as running totals over a shift line, so each sum costs one add and one subtract.
// Stalls: while result is held off, the result register keeps its request
//   and the input register fills; sensor.ready drops only when both are full.
// Reset: clears the gas history, the running sums, the fill count and both
//   valid flags; the first rounds see the cleared history as zero readings.
module environment_alarm_controller_unit #(
	parameter int unsigned HISTORY_DEPTH = 10
) (
	input logic         clk,
	input logic         arst_n,
	eac_sensor_if.sink  sensor,
	eac_result_if.source result
);

	localparam int unsigned WIN = HISTORY_DEPTH / 2;
	localparam int unsigned SW  = $clog2(WIN * 4096);
	localparam int unsigned FW  = $clog2(HISTORY_DEPTH + 1);

	logic [11:0]   hist_q [HISTORY_DEPTH];
	logic [SW-1:0] recent_q, older_q;
	logic [FW-1:0] fill_q;

	logic [SW-1:0] recent_nx, older_nx;
	logic [FW-1:0] fill_nx;

	logic             valid_s1;
	eac_pkg::sensor_t in_s1;
	logic [SW-1:0]    recent_s1, older_s1;
	logic             trend_ok_s1;

	logic             out_valid_q;
	eac_pkg::result_t res_q;
	eac_pkg::result_t res_d;

	logic accept, advance;

	assign advance      = !out_valid_q || result.ready;
	assign sensor.ready = !valid_s1 || advance;
	assign accept       = sensor.valid && sensor.ready;

	assign result.valid = out_valid_q;
	assign result.data  = res_q;

	// running window sums after the new reading enters
	always_comb begin
		recent_nx = recent_q + SW'(sensor.data.gas_adc) - SW'(hist_q[WIN-1]);
		older_nx  = older_q + SW'(hist_q[WIN-1]) - SW'(hist_q[HISTORY_DEPTH-1]);
		if (fill_q < FW'(HISTORY_DEPTH)) begin
			fill_nx = fill_q + FW'(1);
		end else begin
			fill_nx = fill_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
			recent_q <= '0;
			older_q  <= '0;
			fill_q   <= '0;
		end else if (accept) begin
			hist_q[0] <= sensor.data.gas_adc;
			for (int i = 1; i < HISTORY_DEPTH; i++) begin
				hist_q[i] <= hist_q[i-1];
			end
			recent_q <= recent_nx;
			older_q  <= older_nx;
			fill_q   <= fill_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (sensor.ready) begin
				valid_s1 <= sensor.valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_s1       <= sensor.data;
			recent_s1   <= recent_nx;
			older_s1    <= older_nx;
			trend_ok_s1 <= (fill_nx >= FW'(WIN));
		end
		if (advance && valid_s1) begin
			res_q <= res_d;
		end
	end

	// result logic
	logic signed [12:0] st;
	logic [10:0]        sh;
	logic [16:0]        lux_sum;
	logic [15:0]        lux;
	logic               motion, shake;
	logic [11:0]        gas;

	logic signed [13:0] td;
	logic [13:0]        t_abs;
	logic signed [11:0] hd;
	logic [10:0]        h_abs;
	logic signed [16:0] ld;
	logic [16:0]        l_abs;
	logic [11:0]        t_sc, h_sc, l_sc;
	logic [15:0]        c_raw, c_cl;
	logic [23:0]        c_prod;

	logic [6:0]         fan;
	logic               fire, intr, rising, gas_trip;
	logic [SW:0]        older_m;
	eac_pkg::alarm_t    alarm;
	eac_pkg::relay_t    relay;

	always_comb begin
		st      = {in_s1.temp_a[11], in_s1.temp_a} + {in_s1.temp_b[11], in_s1.temp_b};
		sh      = {1'b0, in_s1.humid_a} + {1'b0, in_s1.humid_b};
		lux_sum = {1'b0, in_s1.light_a} + {1'b0, in_s1.light_b};
		lux     = lux_sum[16:1];
		motion  = in_s1.motion_a | in_s1.motion_b;
		shake   = in_s1.shake_a | in_s1.shake_b;
		gas     = in_s1.gas_adc;

		td    = {st[12], st} - 14'sd480;
		t_abs = td[13] ? 14'(-td) : 14'(td);
		t_sc  = (t_abs >= 14'd500) ? 12'd0 : 12'd4000 - {t_abs[8:0], 3'b000};

		hd    = $signed({1'b0, sh}) - 12'sd1000;
		h_abs = hd[11] ? 11'(-hd) : 11'(hd);
		h_sc  = (h_abs >= 11'd1000) ? 12'd0 : 12'd4000 - {h_abs[9:0], 2'b00};

		ld    = $signed({1'b0, lux}) - 17'sd500;
		l_abs = ld[16] ? 17'(-ld) : 17'(ld);
		l_sc  = (l_abs >= 17'd800) ? 12'd0 :
			12'd4000 - ({l_abs[9:0], 2'b00} + 12'(l_abs[9:0]));

		c_raw = {2'b00, t_sc, 2'b00} + {4'b0000, t_sc}
			+ {3'b000, h_sc, 1'b0} + {4'b0000, h_sc}
			+ {3'b000, l_sc, 1'b0}
			+ (motion ? eac_pkg::MOTION_BONUS : 16'd0);
		c_cl   = (c_raw > eac_pkg::COMFORT_MAX) ? eac_pkg::COMFORT_MAX : c_raw;
		c_prod = c_cl[15:4] * eac_pkg::COMFORT_RECIP;

		priority if (st <= 13'sd520) fan = 7'd0;
		else if (st <= 13'sd600) fan = 7'd30;
		else if (st <= 13'sd640) fan = 7'd60;
		else if (st <= 13'sd680) fan = 7'd80;
		else fan = 7'd90;

		fire = (gas > 12'd500) && (st > 13'sd800);
		intr = motion && shake;

		older_m  = {1'b0, older_s1} + (SW+1)'(eac_pkg::TREND_MARGIN);
		rising   = trend_ok_s1 && ({1'b0, recent_s1} > older_m);
		gas_trip = (gas >= 12'd600) || (rising && gas > 12'd400);

		res_d = '0;
		res_d.comfort   = c_prod[eac_pkg::COMFORT_SHIFT+6:eac_pkg::COMFORT_SHIFT];
		res_d.fan_level = fan;

		if (motion) begin
			priority if (lux < 16'd100) res_d.lamp_count = 3'd4;
			else if (lux < 16'd200) res_d.lamp_count = 3'd3;
			else if (lux < 16'd300) res_d.lamp_count = 3'd2;
			else if (lux < 16'd400) res_d.lamp_count = 3'd1;
			else res_d.lamp_count = 3'd0;
		end

		priority if (gas < 12'd200) res_d.gas_band = 2'd0;
		else if (gas < 12'd400) res_d.gas_band = 2'd1;
		else if (gas < 12'd600) res_d.gas_band = 2'd2;
		else res_d.gas_band = 2'd3;

		res_d.hazard_pts = ((st > 13'sd600) ? 7'd10 : 7'd0)
			+ ((st > 13'sd800) ? 7'd20 : 7'd0)
			+ ((sh > 11'd1600) ? 7'd10 : 7'd0)
			+ ((gas > 12'd400) ? 7'd30 : 7'd0)
			+ (motion ? 7'd10 : 7'd0)
			+ (shake ? 7'd20 : 7'd0);

		res_d.fire_risk      = fire;
		res_d.intrusion_flag = intr;

		priority if (gas_trip) begin
			alarm               = eac_pkg::ALARM_GAS;
			res_d.fan_on        = 1'b1;
			res_d.fan_speed_cmd = 7'd90;
			relay               = eac_pkg::RELAY_OFF;
			res_d.siren_on      = 1'b1;
		end else if (fire) begin
			alarm               = eac_pkg::ALARM_FIRE;
			res_d.fan_on        = 1'b1;
			res_d.fan_speed_cmd = 7'd90;
			relay               = eac_pkg::RELAY_KEEP;
			res_d.siren_on      = 1'b1;
		end else if (intr) begin
			alarm               = eac_pkg::ALARM_INTRUSION;
			res_d.fan_on        = 1'b0;
			res_d.fan_speed_cmd = 7'd0;
			relay               = eac_pkg::RELAY_ON;
			res_d.siren_on      = 1'b1;
		end else begin
			alarm               = eac_pkg::ALARM_NONE;
			res_d.fan_on        = (fan != 7'd0);
			res_d.fan_speed_cmd = fan;
			res_d.siren_on      = 1'b0;
			priority if (motion && lux < 16'd300) relay = eac_pkg::RELAY_ON;
			else if (!motion || lux > 16'd800) relay = eac_pkg::RELAY_OFF;
			else relay = eac_pkg::RELAY_KEEP;
		end

		res_d.alarm_kind  = alarm;
		res_d.light_relay = relay;
	end

endmodule
